### rtl/ptrs_pkg.sv
// Package for the periodic task release scheduler.
// Holds the slot count, derived widths, word types and the cell control struct.
// Used by every module of the block; depends on nothing.
package ptrs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int STEP_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CMP_W     = 8;
  localparam int MASK_W    = 16;
  localparam int CAP_W     = 5;
  localparam int PADDR_W   = 3;

  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = PADDR_W'(0);
  localparam logic [CAP_W-1:0]   CAPACITY_RST  = CAP_W'(16);

  localparam logic ACTION_ADD  = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] release_period;
    logic [31:0] start_delay;
  } in_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] due_mask;
    logic              add_accepted;
    logic [CAP_W-1:0]  tasks_in_use;
  } out_word_t;

  typedef struct packed {
    logic [31:0] countdown;
    logic [31:0] reload_period;
  } slot_t;

  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctrl_t;

endpackage

### rtl/periodic_task_release_scheduler.sv
// Periodic task release scheduler: a ring of MAX_TASKS slot cells rotating past one tick unit.
// Add word: result registered in the cycle after acceptance. Tick word: the ring rotates one
// slot per cycle while in S_TICK, then S_DONE registers the due mask once the output is free.
// Words are taken only in S_IDLE, not mid-tick; the single tick unit is at the ring head.
// Reset clears the task count and sets capacity to 16; slot contents are not reset.
// Depends on ptrs_pkg, ptrs_cell and ptrs_tick.
module periodic_task_release_scheduler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ptrs_pkg::in_word_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ptrs_pkg::out_word_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptrs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ptrs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CAP_W-1:0]  cap_q;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  slot_t      slots [MAX_TASKS];
  slot_t      head_next;
  slot_t      load_slot;
  logic       head_active, head_released;
  logic       out_free, in_acc, add_ok, shift_en;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign add_ok     = (CMP_W'(used_q) < CMP_W'(cap_q)) && (CMP_W'(used_q) < CMP_W'(MAX_TASKS));
  assign shift_en   = (state_q == S_TICK);
  assign head_active = CNT_W'(step_q) < used_q;

  assign load_slot.countdown     = in_data_i.start_delay;
  assign load_slot.reload_period = in_data_i.release_period;

  ptrs_tick u_tick (
    .slot_i     (slots[0]),
    .active_i   (head_active),
    .slot_o     (head_next),
    .released_o (head_released)
  );

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_ring
    cell_ctrl_t ctrl;
    slot_t      shift_in;
    assign ctrl.shift_en = shift_en;
    assign ctrl.load_en  = in_acc && (in_data_i.action == ACTION_ADD) && add_ok
                           && (used_q == CNT_W'(g));
    if (g == MAX_TASKS - 1) begin : g_tail
      assign shift_in = head_next;
    end else begin : g_body
      assign shift_in = slots[g+1];
    end
    ptrs_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .shift_i (shift_in),
      .load_i  (load_slot),
      .slot_o  (slots[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    used_d      = used_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.action == ACTION_ADD) begin
            out_d.due_mask     = '0;
            out_d.add_accepted = add_ok;
            out_d.tasks_in_use = add_ok ? CAP_W'(used_q + CNT_W'(1)) : CAP_W'(used_q);
            out_valid_d        = 1'b1;
            if (add_ok) begin
              used_d = used_q + CNT_W'(1);
            end
          end else begin
            mask_d  = '0;
            step_d  = '0;
            state_d = S_TICK;
          end
        end
      end
      S_TICK: begin
        for (int j = 0; j < MASK_W; j++) begin
          if (head_released && (int'(step_q) == j)) begin
            mask_d[j] = 1'b1;
          end
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(MAX_TASKS - 1)) begin
          step_d  = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d.due_mask     = mask_q;
          out_d.add_accepted = 1'b0;
          out_d.tasks_in_use = CAP_W'(used_q);
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      cap_q       <= CAPACITY_RST;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && (paddr == ADDR_CAPACITY)) begin
        cap_q <= pwdata[CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == ADDR_CAPACITY) ? 32'(cap_q) : 32'd0;

endmodule

### rtl/ptrs_cell.sv
// One task slot of the rotating ring: countdown and reload period.
// Loads a new task or takes its neighbour's slot on each shift.
// Depends on ptrs_pkg.
module ptrs_cell (
  input  logic                clk_i,
  input  ptrs_pkg::cell_ctrl_t ctrl_i,
  input  ptrs_pkg::slot_t     shift_i,
  input  ptrs_pkg::slot_t     load_i,
  output ptrs_pkg::slot_t     slot_o
);
  import ptrs_pkg::*;

  slot_t slot_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en) begin
      slot_q <= load_i;
    end else if (ctrl_i.shift_en) begin
      slot_q <= shift_i;
    end
  end

  assign slot_o = slot_q;

endmodule

### rtl/ptrs_tick.sv
// Tick update for the slot at the head of the ring.
// Counts down, detects release and reloads with period minus one.
// Depends on ptrs_pkg.
module ptrs_tick (
  input  ptrs_pkg::slot_t slot_i,
  input  logic            active_i,
  output ptrs_pkg::slot_t slot_o,
  output logic            released_o
);
  import ptrs_pkg::*;

  logic [31:0] dec;

  always_comb begin
    dec        = (slot_i.countdown != 32'd0) ? slot_i.countdown - 32'd1 : slot_i.countdown;
    released_o = active_i && (dec == 32'd0);
    slot_o     = slot_i;
    if (released_o) begin
      slot_o.countdown = slot_i.reload_period - 32'd1;
    end else if (active_i) begin
      slot_o.countdown = dec;
    end
  end

endmodule
